[src/a85_pkg.sv]
// Shared types and constants for the Ascii85 encoder.
// Used by every module of the block; no dependencies of its own.
package a85_pkg;

  localparam int unsigned NUM_DIGITS   = 5;
  localparam int unsigned FIFO_DEPTH   = 2;

  localparam logic [6:0]  DIGIT_OFFSET = 7'd33;
  localparam logic [6:0]  ZERO_CHAR    = 7'd122;
  localparam logic [7:0]  DIGIT_BASE   = 8'd85;

  // ceil(2^38 / 85): exact quotient by 85 for every 32-bit dividend.
  localparam logic [31:0] RECIP_85     = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT  = 38;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } out_t;

  // One complete group handed from the front end to the conversion back end.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  ndig;
    logic        zero;
    logic        last;
  } job_t;

endpackage

[src/a85_front.sv]
// Front end: collects input bytes into groups of four and issues group requests.
// Depends on a85_pkg.
module a85_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  a85_pkg::in_t    in_data,
  input  logic            q_full,
  output logic            q_push,
  output a85_pkg::job_t   q_job
);

  logic [23:0] pend_bytes_r, pend_bytes_nxt;
  logic [1:0]  pend_count_r, pend_count_nxt;
  logic        accept;
  logic        group_done;
  logic [31:0] word;

  assign in_ready   = ~q_full;
  assign accept     = in_valid & in_ready;
  assign group_done = (pend_count_r == 2'd3) | in_data.end_of_data;
  assign q_push     = accept & group_done;

  // Pad a short group with zero bytes on the right.
  always_comb begin
    case (pend_count_r)
      2'd0:    word = {in_data.data_byte, 24'd0};
      2'd1:    word = {pend_bytes_r[7:0], in_data.data_byte, 16'd0};
      2'd2:    word = {pend_bytes_r[15:0], in_data.data_byte, 8'd0};
      default: word = {pend_bytes_r, in_data.data_byte};
    endcase
  end

  always_comb begin
    q_job.word = word;
    q_job.ndig = (pend_count_r == 2'd3) ? 3'd5 : ({1'b0, pend_count_r} + 3'd2);
    q_job.zero = (pend_count_r == 2'd3) & (word == 32'd0);
    q_job.last = in_data.end_of_data;
  end

  always_comb begin
    pend_bytes_nxt = pend_bytes_r;
    pend_count_nxt = pend_count_r;
    if (accept) begin
      if (group_done) begin
        pend_bytes_nxt = 24'd0;
        pend_count_nxt = 2'd0;
      end else begin
        pend_bytes_nxt = {pend_bytes_r[15:0], in_data.data_byte};
        pend_count_nxt = pend_count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bytes_r <= 24'd0;
      pend_count_r <= 2'd0;
    end else begin
      pend_bytes_r <= pend_bytes_nxt;
      pend_count_r <= pend_count_nxt;
    end
  end

endmodule

[src/a85_fifo.sv]
// Short register queue of group requests between front end and back end.
// Depends on a85_pkg.
module a85_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  a85_pkg::job_t   push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output a85_pkg::job_t   head_job
);

  a85_pkg::job_t mem_r [a85_pkg::FIFO_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == 2'(a85_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/a85_back.sv]
// Back end: converts a group word into base-85 digits and emits characters.
// Depends on a85_pkg.
module a85_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  a85_pkg::job_t   job,
  output logic            job_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output a85_pkg::out_t   out_data
);

  localparam logic [1:0] CV_IDLE = 2'd0;
  localparam logic [1:0] CV_RUN  = 2'd1;
  localparam logic [1:0] CV_DONE = 2'd2;

  // Conversion unit: one divide-by-85 step per cycle, least significant digit first.
  logic [1:0]  cv_state_r, cv_state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] w_r;
  logic [6:0]  dig_r [a85_pkg::NUM_DIGITS];
  logic [2:0]  cv_ndig_r;
  logic        cv_zero_r;
  logic        cv_last_r;

  // Emitter: walks the stored digits most significant first.
  logic        em_busy_r, em_busy_nxt;
  logic [2:0]  em_idx_r, em_idx_nxt;
  logic [6:0]  em_dig_r [a85_pkg::NUM_DIGITS];
  logic [2:0]  em_ndig_r;
  logic        em_zero_r;
  logic        em_last_r;

  logic          out_valid_r, out_valid_nxt;
  a85_pkg::out_t out_data_r;

  logic [63:0] prod;
  logic [25:0] quot;
  logic [9:0]  sum1;
  logic [8:0]  sum2;
  logic [7:0]  sum3;
  logic [7:0]  mod255;
  logic [6:0]  rem;

  logic        out_load;
  logic        em_at_end;
  logic        emit_free;
  logic        handoff;
  logic        load_job;

  // Quotient by reciprocal multiplication; remainder from the byte sum,
  // since 256 is congruent to 1 modulo 255 and 85 divides 255.
  assign prod = 64'(w_r) * 64'(a85_pkg::RECIP_85);
  assign quot = prod[63:a85_pkg::RECIP_SHIFT];

  always_comb begin
    sum1   = {2'd0, w_r[31:24]} + {2'd0, w_r[23:16]} + {2'd0, w_r[15:8]} + {2'd0, w_r[7:0]};
    sum2   = {1'b0, sum1[7:0]} + {7'd0, sum1[9:8]};
    sum3   = sum2[7:0] + {7'd0, sum2[8]};
    mod255 = (sum3 == 8'd255) ? 8'd0 : sum3;
    if (mod255 >= 8'(2 * a85_pkg::DIGIT_BASE)) begin
      rem = 7'(mod255 - 8'(2 * a85_pkg::DIGIT_BASE));
    end else if (mod255 >= a85_pkg::DIGIT_BASE) begin
      rem = 7'(mod255 - a85_pkg::DIGIT_BASE);
    end else begin
      rem = mod255[6:0];
    end
  end

  assign out_load  = em_busy_r & (~out_valid_r | out_ready);
  assign em_at_end = (em_idx_r == 3'(em_ndig_r - 3'd1));
  assign emit_free = ~em_busy_r | (out_load & em_at_end);
  assign handoff   = (cv_state_r == CV_DONE) & emit_free;
  assign job_pop   = job_valid & ((cv_state_r == CV_IDLE) | handoff);
  assign load_job  = job_pop;

  always_comb begin
    cv_state_nxt = cv_state_r;
    step_nxt     = step_r;
    case (cv_state_r)
      CV_IDLE: begin
        if (load_job) begin
          cv_state_nxt = job.zero ? CV_DONE : CV_RUN;
          step_nxt     = 3'd0;
        end
      end
      CV_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(a85_pkg::NUM_DIGITS - 1)) begin
          cv_state_nxt = CV_DONE;
        end
      end
      CV_DONE: begin
        if (handoff) begin
          if (load_job) begin
            cv_state_nxt = job.zero ? CV_DONE : CV_RUN;
            step_nxt     = 3'd0;
          end else begin
            cv_state_nxt = CV_IDLE;
          end
        end
      end
      default: begin
        cv_state_nxt = CV_IDLE;
      end
    endcase
  end

  always_comb begin
    em_busy_nxt = em_busy_r;
    em_idx_nxt  = em_idx_r;
    if (handoff) begin
      em_busy_nxt = 1'b1;
      em_idx_nxt  = 3'd0;
    end else if (out_load) begin
      em_idx_nxt = em_idx_r + 3'd1;
      if (em_at_end) begin
        em_busy_nxt = 1'b0;
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load_job) begin
      w_r       <= job.word;
      cv_ndig_r <= job.zero ? 3'd1 : job.ndig;
      cv_zero_r <= job.zero;
      cv_last_r <= job.last;
    end else if (cv_state_r == CV_RUN) begin
      w_r                                                  <= {6'd0, quot};
      dig_r[3'(3'(a85_pkg::NUM_DIGITS - 1) - step_r)]      <= rem;
    end
    if (handoff) begin
      em_dig_r  <= dig_r;
      em_ndig_r <= cv_ndig_r;
      em_zero_r <= cv_zero_r;
      em_last_r <= cv_last_r;
    end
    if (out_load) begin
      out_data_r.out_char  <= em_zero_r ? a85_pkg::ZERO_CHAR
                                        : (em_dig_r[em_idx_r] + a85_pkg::DIGIT_OFFSET);
      out_data_r.last_char <= em_last_r & em_at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_state_r  <= CV_IDLE;
      step_r      <= 3'd0;
      em_busy_r   <= 1'b0;
      em_idx_r    <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cv_state_r  <= cv_state_nxt;
      step_r      <= step_nxt;
      em_busy_r   <= em_busy_nxt;
      em_idx_r    <= em_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/ascii85_encoder.sv]
// Ascii85 stream encoder. One raw byte is taken per cycle whenever the two-entry
// group queue has room; each group of four bytes (or the short group closed by
// end_of_data) becomes one request. The back end turns a request into digits with
// one shared divide-by-85 unit, one digit per cycle; a group occupies it for a load
// plus five steps, and an all-zero group skips the steps. Characters leave through a
// registered output stage, one per cycle while the receiver is ready, as the next
// group converts. Sustained throughput is set by the divide-by-85 unit. The last
// byte of a group passes through the queue, the conversion unit and the emitter
// before its first character reaches the output register.
module ascii85_encoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  a85_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output a85_pkg::out_t   out_data
);

  logic          q_full;
  logic          q_push;
  a85_pkg::job_t q_push_job;
  logic          q_pop;
  logic          q_head_valid;
  a85_pkg::job_t q_head_job;

  a85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  a85_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  a85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_head_valid),
    .job       (q_head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[src/a85_checker.sv]
// Port-level checks for the Ascii85 encoder, attached to the top level by bind.
// Depends on a85_pkg and ascii85_encoder.
module a85_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input a85_pkg::in_t    in_data,
  input logic            out_valid,
  input logic            out_ready,
  input a85_pkg::out_t   out_data
);

  // A stalled input request holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input request changed while stalled");

  // A stalled result request holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // Every character is a base-85 digit or the zero-group mark.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_char >= a85_pkg::DIGIT_OFFSET &&
                   out_data.out_char <= 7'd117) ||
                  out_data.out_char == a85_pkg::ZERO_CHAR)
    else $error("character out of range");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // The group queue is empty after reset, so input is taken.
  assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind ascii85_encoder a85_checker u_a85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[bench/tb_ascii85_encoder.sv]
// Self-checking testbench for ascii85_encoder: directed byte streams, then random streams
// under several idling patterns. It depends only on a85_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_ascii85_encoder;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 30;
  localparam int ITEMS_PER_PASS = 48;

  typedef struct {
    logic [7:0] data_byte;
    bit         eod;
    bit         typed;
    string      text;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  a85_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  a85_pkg::out_t out_data;

  // Open group of the encoder as the checker sees it.
  logic [23:0] grp_bytes = '0;
  logic [1:0]  grp_count = '0;

  a85_pkg::out_t exp_chars [$];
  int   n_err = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_seq = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   idle_tab  [4] = '{0, 49, 0, 13};
  int   stall_tab [4] = '{0, 0, 49, 13};

  // Typed text is given only where the result is plain from the Ascii85 rules.
  dir_row_t dir_rows [25] = '{
    '{8'h00, 1'b0, 1'b1, ""}, '{8'h00, 1'b0, 1'b1, ""},
    '{8'h00, 1'b0, 1'b1, ""}, '{8'h00, 1'b0, 1'b1, "z"},
    '{8'hFF, 1'b0, 1'b1, ""}, '{8'hFF, 1'b0, 1'b1, ""},
    '{8'hFF, 1'b0, 1'b1, ""}, '{8'hFF, 1'b1, 1'b1, "s8W-!"},
    '{8'h00, 1'b1, 1'b1, "!!"},
    '{8'h00, 1'b0, 1'b1, ""}, '{8'h00, 1'b0, 1'b1, ""},
    '{8'h00, 1'b1, 1'b1, "!!!!"},
    '{8'h4D, 1'b0, 1'b1, ""}, '{8'h61, 1'b0, 1'b1, ""},
    '{8'h6E, 1'b0, 1'b1, ""}, '{8'h20, 1'b0, 1'b1, "9jqo^"},
    '{8'h12, 1'b0, 1'b0, ""}, '{8'h34, 1'b0, 1'b0, ""},
    '{8'h56, 1'b1, 1'b0, ""},
    '{8'h80, 1'b0, 1'b0, ""}, '{8'h01, 1'b1, 1'b0, ""},
    '{8'h00, 1'b0, 1'b1, ""}, '{8'h00, 1'b0, 1'b1, ""},
    '{8'h00, 1'b0, 1'b1, ""}, '{8'h00, 1'b1, 1'b1, "z"}
  };

  ascii85_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Adds one byte to the open group and returns the characters it releases.
  task automatic encode_byte(input a85_pkg::in_t r, output int unsigned cnt,
                             output a85_pkg::out_t res [5]);
    int unsigned n;
    int unsigned emit;
    int          i;
    logic [31:0] word;
    logic [6:0]  dig [5];
    n = grp_count + 1;
    cnt = 0;
    if (n < 4 && !r.end_of_data) begin
      grp_bytes = {grp_bytes[15:0], r.data_byte};
      grp_count = n[1:0];
      return;
    end
    word = {grp_bytes, r.data_byte};
    word = word << (8 * (4 - n));
    grp_bytes = '0;
    grp_count = '0;
    if (n == 4 && word == 32'd0) begin
      res[0].out_char = a85_pkg::ZERO_CHAR;
      res[0].last_char = r.end_of_data;
      cnt = 1;
      return;
    end
    for (i = 4; i >= 0; i--) begin
      dig[i] = 7'(word % a85_pkg::DIGIT_BASE);
      word = word / a85_pkg::DIGIT_BASE;
    end
    emit = (n == 4) ? 5 : n + 1;
    for (i = 0; i < int'(emit); i++) begin
      res[i].out_char = dig[i] + a85_pkg::DIGIT_OFFSET;
      res[i].last_char = r.end_of_data && (i == int'(emit) - 1);
    end
    cnt = emit;
  endtask

  // Offers one request, waits for it to be taken, then queues what it should produce.
  task automatic send_req(input a85_pkg::in_t r, input bit typed, input string text);
    int unsigned   cnt;
    a85_pkg::out_t res [5];
    a85_pkg::out_t c;
    logic [7:0]    ch;
    int            k;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    encode_byte(r, cnt, res);
    if (typed) begin
      for (k = 0; k < text.len(); k++) begin
        ch = text[k];
        c.out_char = ch[6:0];
        c.last_char = r.end_of_data && (k == text.len() - 1);
        exp_chars.push_back(c);
      end
    end else begin
      for (k = 0; k < int'(cnt); k++) exp_chars.push_back(res[k]);
    end
  endtask

  // Random streams: mostly ordinary bytes, some all-zero streams and aligned zero groups.
  task automatic send_streams(input int n_items);
    int   sent;
    int   len;
    int   kind;
    int   i;
    int   pick;
    a85_pkg::in_t r;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
      kind = $urandom_range(7);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(9);
        if (kind == 0 || (kind == 1 && (i / 4) % 2 == 0)) r.data_byte = 8'h00;
        else if (pick == 0) r.data_byte = 8'h00;
        else if (pick == 1) r.data_byte = 8'hFF;
        else r.data_byte = 8'($urandom_range(255));
        r.end_of_data = (i == len - 1);
        send_req(r, 1'b0, "");
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_chars.size() == 0) begin
          $display("%t: unexpected character %0d last %0d", $time, out_data.out_char,
                   out_data.last_char);
          n_err++;
        end else begin
          if (out_data.out_char !== exp_chars[0].out_char) begin
            $display("%t: out_char expected %0d, got %0d", $time, exp_chars[0].out_char,
                     out_data.out_char);
            n_err++;
          end
          if (out_data.last_char !== exp_chars[0].last_char) begin
            $display("%t: last_char expected %0d, got %0d", $time, exp_chars[0].last_char,
                     out_data.last_char);
            n_err++;
          end
          void'(exp_chars.pop_front());
        end
      end
      if (hold_seq != hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = hold_seq;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_ascii85_encoder failed");
        $finish;
      end
    end
  end

  initial begin
    int           p;
    a85_pkg::in_t r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r.data_byte = dir_rows[i].data_byte;
      r.end_of_data = dir_rows[i].eod;
      send_req(r, dir_rows[i].typed, dir_rows[i].text);
    end

    for (p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct <= stall_tab[p];
      // Long receiver hold-off while requests keep coming, so the input side backs up.
      if (p == 0) hold_seq <= hold_seq + 1;
      send_streams(ITEMS_PER_PASS);
    end
    in_valid <= 1'b0;

    while (exp_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_ascii85_encoder passed");
    end else begin
      $display("tb_ascii85_encoder failed");
    end
    $finish;
  end

endmodule
